@@ rtl/rmsc_pkg.sv @@
// Shared types, constants and the sequencer program for the RSA symbol cipher.
`timescale 1ns / 1ps
`default_nettype none

package rmsc_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned EXP_W      = 31;
    localparam int unsigned CFG_W      = 32;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned RED_CNT_W  = 5;
    localparam int unsigned STEP_W     = 4;

    localparam logic [7:0] SYM_OFFSET = 8'd96;

    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PUB_EXP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIV_EXP = 2'd2;

    localparam logic [RED_CNT_W-1:0] RED_LAST = 5'd31;
    localparam logic [4:0]           BIT_LAST = 5'd30;

    typedef struct packed {
        logic               op;
        logic signed [7:0]  char_in;
        logic signed [31:0] cipher_in;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] residue;
        logic [7:0]         out_char;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic use_mul;
        logic step;
    } t_mr_ctl;

    typedef struct packed {
        logic last;
    } t_mr_sts;

    typedef logic [STEP_W-1:0] t_step;

    typedef enum logic [3:0] {
        U_IDLE,
        U_LOAD,
        U_RED_SQ,
        U_TEST,
        U_MUL_ACC,
        U_RED_ACC,
        U_MUL_SQ,
        U_SHIFT,
        U_EMIT
    } t_uop;

    typedef enum logic [2:0] {
        C_NEXT,
        C_WAIT_IN,
        C_RED,
        C_SKIP_MUL,
        C_LOOP,
        C_OUT
    } t_cond;

    typedef struct packed {
        t_uop  op;
        t_cond cond;
        t_step target;
    } t_uword;

    localparam t_step S_WAIT  = 4'd0;
    localparam t_step S_LOAD  = 4'd1;
    localparam t_step S_RED0  = 4'd2;
    localparam t_step S_TEST  = 4'd3;
    localparam t_step S_MULA  = 4'd4;
    localparam t_step S_REDA  = 4'd5;
    localparam t_step S_MULS  = 4'd6;
    localparam t_step S_REDS  = 4'd7;
    localparam t_step S_SHIFT = 4'd8;
    localparam t_step S_EMIT  = 4'd9;

    // square-and-multiply program, LSB first
    function automatic t_uword ucode(input t_step step);
        t_uword w;
        unique case (step)
            S_WAIT:  w = '{op: U_IDLE,    cond: C_WAIT_IN,  target: S_LOAD};
            S_LOAD:  w = '{op: U_LOAD,    cond: C_NEXT,     target: S_RED0};
            S_RED0:  w = '{op: U_RED_SQ,  cond: C_RED,      target: S_TEST};
            S_TEST:  w = '{op: U_TEST,    cond: C_SKIP_MUL, target: S_MULS};
            S_MULA:  w = '{op: U_MUL_ACC, cond: C_NEXT,     target: S_REDA};
            S_REDA:  w = '{op: U_RED_ACC, cond: C_RED,      target: S_MULS};
            S_MULS:  w = '{op: U_MUL_SQ,  cond: C_NEXT,     target: S_REDS};
            S_REDS:  w = '{op: U_RED_SQ,  cond: C_RED,      target: S_SHIFT};
            S_SHIFT: w = '{op: U_SHIFT,   cond: C_LOOP,     target: S_TEST};
            S_EMIT:  w = '{op: U_EMIT,    cond: C_OUT,      target: S_WAIT};
            default: w = '{op: U_IDLE,    cond: C_NEXT,     target: S_WAIT};
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

@@ rtl/rmsc_mulred.sv @@
// Multiplier and bit-serial remainder unit: (a*b) mod n or a mod n, one bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module rmsc_mulred (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire rmsc_pkg::t_mr_ctl    i_ctl,
    input  wire logic [31:0]          i_a,
    input  wire logic [31:0]          i_b,
    input  wire logic [31:0]          i_mod,
    output rmsc_pkg::t_mr_sts         o_sts,
    output logic [31:0]               o_rem
);
    import rmsc_pkg::*;

    logic [WORD_W-1:0]    r_hi;
    logic [WORD_W-1:0]    r_lo;
    logic [RED_CNT_W-1:0] r_cnt;
    logic [2*WORD_W-1:0]  prod;
    logic [WORD_W:0]      trial;
    logic [WORD_W:0]      nx;
    logic [WORD_W:0]      diff;

    assign prod  = 64'(i_a) * 64'(i_b);
    assign trial = {r_hi, r_lo[WORD_W-1]};
    assign nx    = {1'b0, i_mod};
    assign diff  = trial - nx;
    assign o_rem = (trial >= nx) ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
    assign o_sts.last = (r_cnt == RED_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_ctl.load) begin
            r_cnt <= '0;
        end else if (i_ctl.step) begin
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            if (i_ctl.use_mul) begin
                {r_hi, r_lo} <= prod;
            end else begin
                r_hi <= '0;
                r_lo <= i_a;
            end
        end else if (i_ctl.step) begin
            r_hi <= o_rem;
            r_lo <= {r_lo[WORD_W-2:0], 1'b0};
        end
    end

endmodule

`default_nettype wire

@@ rtl/rsa_modexp_symbol_cipher.sv @@
// Top level: microcoded square-and-multiply modular exponentiation of one item.
// Each modular multiply is a multiplier load followed by bit-serial remainder steps; the
// multiply into the accumulator is skipped for exponent bits that are clear.
// One item in flight; the next is taken once the result is in the output register.
// Synchronous active-low reset: keys to 1, sequencer to wait, output empty.
`timescale 1ns / 1ps
`default_nettype none

module rsa_modexp_symbol_cipher #(
    parameter int unsigned MOD_BITS = 31
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire rmsc_pkg::t_in_item                i_in_item,
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output rmsc_pkg::t_out_item                    o_out_item,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [rmsc_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [rmsc_pkg::CFG_W-1:0]        i_cfg_data
);
    import rmsc_pkg::*;

    logic [MOD_BITS-1:0] r_mod;
    logic [EXP_W-1:0]    r_pexp;
    logic [EXP_W-1:0]    r_sexp;
    t_step               r_step;
    t_step               n_step;
    logic [EXP_W-1:0]    r_exp;
    logic [WORD_W-1:0]   r_mag;
    logic                r_neg;
    logic                r_odd;
    logic                r_zero;
    logic [WORD_W-1:0]   r_acc;
    logic [WORD_W-1:0]   r_sq;
    logic [4:0]          r_bit;
    logic                r_out_valid;
    t_out_item           r_out;

    t_uword              uw;
    t_mr_ctl             mr_ctl;
    t_mr_sts             mr_sts;
    logic [WORD_W-1:0]   rem_next;
    logic [WORD_W-1:0]   mod32;
    logic [WORD_W-1:0]   n_eff;
    logic [WORD_W-1:0]   op_a;
    logic                in_accept;
    logic                red_last;
    logic                out_blocked;
    logic signed [8:0]   base9;
    logic [8:0]          mag9;
    logic                in_neg;
    logic [WORD_W-1:0]   in_mag;
    logic [EXP_W-1:0]    in_exp;
    logic [WORD_W-1:0]   res;

    assign uw          = ucode(r_step);
    assign o_in_stall  = (uw.op != U_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign out_blocked = r_out_valid && i_out_stall;
    assign red_last    = mr_ctl.step && mr_sts.last;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign mod32 = WORD_W'(r_mod);
    assign n_eff = (mod32 == '0) ? WORD_W'(1) : mod32;

    assign base9 = $signed({i_in_item.char_in[7], i_in_item.char_in}) - $signed({1'b0, SYM_OFFSET});
    assign mag9  = base9[8] ? 9'(-base9) : 9'(base9);

    always_comb begin
        if (!i_in_item.op) begin
            in_neg = base9[8];
            in_mag = WORD_W'(mag9);
            in_exp = r_pexp;
        end else begin
            in_neg = i_in_item.cipher_in[31];
            in_mag = in_neg ? WORD_W'(-i_in_item.cipher_in) : WORD_W'(i_in_item.cipher_in);
            in_exp = r_sexp;
        end
    end

    always_comb begin
        if (r_zero) begin
            res = WORD_W'(1);
        end else if (r_neg && r_odd && (r_acc != '0)) begin
            res = -r_acc;
        end else begin
            res = r_acc;
        end
    end

    always_comb begin
        mr_ctl.load    = (uw.op == U_LOAD) || (uw.op == U_MUL_ACC) || (uw.op == U_MUL_SQ);
        mr_ctl.use_mul = (uw.op == U_MUL_ACC) || (uw.op == U_MUL_SQ);
        mr_ctl.step    = (uw.op == U_RED_SQ) || (uw.op == U_RED_ACC);
        if (uw.op == U_LOAD) begin
            op_a = r_mag;
        end else if (uw.op == U_MUL_ACC) begin
            op_a = r_acc;
        end else begin
            op_a = r_sq;
        end
    end

    always_comb begin
        unique case (uw.cond)
            C_NEXT:     n_step = r_step + 1'b1;
            C_WAIT_IN:  n_step = in_accept ? uw.target : r_step;
            C_RED:      n_step = red_last ? uw.target : r_step;
            C_SKIP_MUL: n_step = r_exp[0] ? t_step'(r_step + 1'b1) : uw.target;
            C_LOOP:     n_step = (r_bit != BIT_LAST) ? uw.target : t_step'(r_step + 1'b1);
            C_OUT:      n_step = out_blocked ? r_step : uw.target;
            default:    n_step = S_WAIT;
        endcase
    end

    rmsc_mulred u_mulred (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mr_ctl),
        .i_a     (op_a),
        .i_b     (r_sq),
        .i_mod   (n_eff),
        .o_sts   (mr_sts),
        .o_rem   (rem_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_WAIT;
            r_mod       <= MOD_BITS'(1);
            r_pexp      <= EXP_W'(1);
            r_sexp      <= EXP_W'(1);
            r_out_valid <= 1'b0;
            r_bit       <= '0;
        end else begin
            r_step <= n_step;
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_MODULUS:  r_mod  <= i_cfg_data[MOD_BITS-1:0];
                    CFG_PUB_EXP:  r_pexp <= i_cfg_data[EXP_W-1:0];
                    CFG_PRIV_EXP: r_sexp <= i_cfg_data[EXP_W-1:0];
                    default: ;
                endcase
            end
            if (uw.op == U_EMIT && !out_blocked) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (in_accept) begin
                r_bit <= '0;
            end else if (uw.op == U_SHIFT) begin
                r_bit <= r_bit + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mag  <= in_mag;
            r_neg  <= in_neg;
            r_exp  <= in_exp;
            r_odd  <= in_exp[0];
            r_zero <= (in_exp == '0);
        end
        if (uw.op == U_LOAD) begin
            r_acc <= (n_eff == WORD_W'(1)) ? '0 : WORD_W'(1);
        end
        if (uw.op == U_RED_SQ && red_last) begin
            r_sq <= rem_next;
        end
        if (uw.op == U_RED_ACC && red_last) begin
            r_acc <= rem_next;
        end
        if (uw.op == U_SHIFT) begin
            r_exp <= {1'b0, r_exp[EXP_W-1:1]};
        end
        if (uw.op == U_EMIT && !out_blocked) begin
            r_out.residue  <= res;
            r_out.out_char <= res[7:0] + SYM_OFFSET;
        end
    end

    a_rem_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        red_last |-> (rem_next < n_eff))
        else $error("remainder not reduced below modulus");

    a_operands_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == S_TEST) |-> ((r_acc < n_eff) && (r_sq < n_eff)))
        else $error("exponent loop operand not reduced");

    a_emit_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step == S_EMIT && !out_blocked) |=> (r_step == S_WAIT && o_out_valid))
        else $error("result not delivered to output register");

    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_step != S_WAIT && r_step != S_EMIT) |-> (r_bit <= BIT_LAST))
        else $error("exponent bit counter overran");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (o_in_stall && r_step == S_LOAD))
        else $error("sequencer did not start after accept");

endmodule

`default_nettype wire
